// ===== hdl/sccp_pkg.sv =====
// sccp_pkg: widths, fixed-point constants and status codes for the segment clipper
// no dependencies
`timescale 1ns / 1ps
package sccp_pkg;

   // coordinate and vertex store geometry
   localparam int CW     = 16;
   localparam int MAXV   = 8;
   localparam int VAW    = 3;
   localparam int CNTW   = 4;

   // shared multiplier operand and product widths
   localparam int MW     = 22;
   localparam int PW     = 2 * MW;

   // edge dot products q and p
   localparam int QW     = 35;

   // unsigned q1.16 parameter
   localparam int TW     = 17;
   localparam int DIV_STEPS = 18;

   localparam logic [TW-1:0] ONE_Q16 = 17'h10000;
   localparam logic [TW-1:0] MAX_Q16 = 17'h1FFFF;

   localparam logic [CNTW-1:0] MIN_COUNT   = 4'd3;
   localparam logic [CNTW-1:0] MAX_COUNT   = 4'd8;
   localparam logic [CNTW-1:0] RESET_COUNT = 4'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CLIP = 1'b1;

   localparam logic [1:0] STAT_VISIBLE  = 2'd0;
   localparam logic [1:0] STAT_REJECTED = 2'd1;
   localparam logic [1:0] STAT_DEGEN    = 2'd2;
   localparam logic [1:0] STAT_LOADED   = 2'd3;

   typedef logic signed [CW-1:0] coord_type;

endpackage

// ===== hdl/sccp_if.sv =====
// sccp_req_if and sccp_rsp_if: valid/ready channels of the segment clipper
// depends on sccp_pkg
`timescale 1ns / 1ps
interface sccp_req_if
   import sccp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [VAW-1:0]   vertex_slot;
   coord_type        ax;
   coord_type        ay;
   coord_type        bx;
   coord_type        by_coord;

   modport source (output valid, opcode, vertex_slot, ax, ay, bx, by_coord, input ready);
   modport sink   (input valid, opcode, vertex_slot, ax, ay, bx, by_coord, output ready);
endinterface

interface sccp_rsp_if
   import sccp_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] status;
   coord_type  out_x0;
   coord_type  out_y0;
   coord_type  out_x1;
   coord_type  out_y1;

   modport source (output valid, status, out_x0, out_y0, out_x1, out_y1, input ready);
   modport sink   (input valid, status, out_x0, out_y0, out_x1, out_y1, output ready);
endinterface

// ===== hdl/sccp_div.sv =====
// sccp_div: restoring divider giving num/den in q1.16, rounded half up, saturated
// one quotient bit per cycle; depends on sccp_pkg
`timescale 1ns / 1ps
module sccp_div
   import sccp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] num,
   input  logic [QW-1:0] den,
   output logic          done,
   output logic [TW-1:0] quo
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [4:0]          it_ff, it_in;
   logic [QW:0]         rem_ff, rem_in;
   logic [QW-1:0]       den_ff, den_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [TW-1:0]       quo_ff, quo_in;

   logic                ge;
   logic [QW:0]         rsub;
   logic [DIV_STEPS-1:0] qn;
   logic [DIV_STEPS:0]  rnd;

   // one restoring step
   always_comb begin
      ge   = rem_ff >= {1'b0, den_ff};
      rsub = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      qn   = {q_ff[DIV_STEPS-2:0], ge};
      rnd  = {1'b0, qn} + {{DIV_STEPS{1'b0}}, 1'b1};
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      it_in   = it_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      quo_in  = quo_ff;
      if (start) begin
         den_in = den;
         if ({1'b0, num} >= {den, 1'b0}) begin
            quo_in  = MAX_Q16;
            done_in = 1'b1;
         end else begin
            rem_in  = {1'b0, num};
            q_in    = '0;
            it_in   = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         q_in   = qn;
         rem_in = {rsub[QW-1:0], 1'b0};
         it_in  = it_ff + 5'd1;
         if (it_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = (rnd[DIV_STEPS:1] > {1'b0, MAX_Q16}) ? MAX_Q16 : rnd[TW:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      it_ff  <= it_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== hdl/segment_clip_convex_polygon_core.sv =====
// Cyrus-Beck convex polygon clipper: the top level with sequencer, shared multiplier and
// vertex store. A load is accepted and handed to its word; a clip is accepted, sums the
// vertices, then per edge forms the dot products and waits for the divider when a division
// runs, then interpolates the endpoints and hands the word off.
// One item is in work at a time; the rate is set by the shared multiplier and divider.
// Synchronous reset clears control and sets vertex_count to 4; the vertex store is not cleared.
`timescale 1ns / 1ps
module segment_clip_convex_polygon_core
   import sccp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   sccp_req_if.sink        req_ch,
   sccp_rsp_if.source      rsp_ch,
   input  logic            csr_we,
   input  logic [CNTW-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SUM  = 9'b000000010,
      ST_RDP  = 9'b000000100,
      ST_RDQ  = 9'b000001000,
      ST_EDGE = 9'b000010000,
      ST_DEC  = 9'b000100000,
      ST_DIVW = 9'b001000000,
      ST_FIN  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [CNTW-1:0] vcount_ff, vcount_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [3:0]      stp_ff, stp_in;
   logic            rdv_ff, rdv_in;
   logic            rej_ff, rej_in;
   logic            dtgt_ff, dtgt_in;
   logic            oneg_ff, oneg_in;
   logic            rvalid_ff, rvalid_in;

   // datapath registers
   coord_type               ax_ff, ax_in, ay_ff, ay_in;
   logic signed [CW:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW+2:0]    sx_ff, sx_in, sy_ff, sy_in;
   coord_type               px_ff, px_in, py_ff, py_in, qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CW+3:0]    npx_ff, npx_in, npy_ff, npy_in;
   logic signed [PW-1:0]    acc_ff, acc_in, prod_ff, prod_in;
   logic signed [QW-1:0]    qv_ff, qv_in, pv_ff, pv_in;
   logic [TW-1:0]           t0_ff, t0_in, t1_ff, t1_in;
   logic [1:0]              stat_ff, stat_in;
   coord_type               x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [1:0]              rstat_ff, rstat_in;
   coord_type               rx0_ff, rx0_in, ry0_ff, ry0_in, rx1_ff, rx1_in, ry1_ff, ry1_in;

   // vertex store, x in the low half
   logic [2*CW-1:0] vmem [MAXV];
   logic [2*CW-1:0] mem_q_ff;
   logic [VAW-1:0]  rd_addr;
   logic            wr_en;

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;

   // divider
   logic            div_start, div_done;
   logic [QW-1:0]   div_num, div_den;
   logic [TW-1:0]   div_quo;

   logic signed [CW:0]   nx, ny;
   logic signed [PW-1:0] sum2, lrp;
   logic signed [QW-1:0] qe, pe;
   logic [CNTW-1:0]      idx_nx;
   logic                 last_edge, accept;
   coord_type            lcoord_a;

   sccp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign idx_nx    = idx_ff + 4'd1;
   assign last_edge = (idx_nx == cnt_ff);

   // edge normal, pointing whichever way; flipped later by the orientation sign
   always_comb begin
      nx = CW'(0) + (CW+1)'(qy_ff) - (CW+1)'(py_ff);
      ny = (CW+1)'(px_ff) - (CW+1)'(qx_ff);
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_EDGE) begin
         case (stp_ff)
            4'd0: begin mul_a = MW'(signed'({1'b0, cnt_ff})); mul_b = MW'(px_ff); end
            4'd1: begin mul_a = MW'(signed'({1'b0, cnt_ff})); mul_b = MW'(py_ff); end
            4'd2: begin mul_a = MW'(nx); mul_b = MW'(sx_ff) - MW'(npx_ff); end
            4'd3: begin mul_a = MW'(ny); mul_b = MW'(sy_ff) - MW'(npy_ff); end
            4'd4: begin mul_a = MW'(nx); mul_b = MW'(ax_ff) - MW'(px_ff); end
            4'd5: begin mul_a = MW'(ny); mul_b = MW'(ay_ff) - MW'(py_ff); end
            4'd6: begin mul_a = MW'(nx); mul_b = MW'(dx_ff); end
            4'd7: begin mul_a = MW'(ny); mul_b = MW'(dy_ff); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_FIN) begin
         case (stp_ff)
            4'd0: begin mul_a = MW'(dx_ff); mul_b = MW'(signed'({1'b0, t0_ff})); end
            4'd1: begin mul_a = MW'(dy_ff); mul_b = MW'(signed'({1'b0, t0_ff})); end
            4'd2: begin mul_a = MW'(dx_ff); mul_b = MW'(signed'({1'b0, t1_ff})); end
            4'd3: begin mul_a = MW'(dy_ff); mul_b = MW'(signed'({1'b0, t1_ff})); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   // accumulated pair, signed dot products after the orientation flip, rounded lerp
   always_comb begin
      sum2 = acc_ff + prod_ff;
      qe   = oneg_ff ? -qv_ff : qv_ff;
      pe   = oneg_ff ? -pv_ff : pv_ff;
      lrp  = (prod_ff + PW'(32768)) >>> 16;
      lcoord_a = ((stp_ff == 4'd1) || (stp_ff == 4'd3)) ? ax_ff : ay_ff;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      vcount_in = vcount_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      stp_in    = stp_ff;
      rdv_in    = 1'b0;
      rej_in    = rej_ff;
      dtgt_in   = dtgt_ff;
      oneg_in   = oneg_ff;
      rvalid_in = rvalid_ff;
      ax_in = ax_ff; ay_in = ay_ff; dx_in = dx_ff; dy_in = dy_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      px_in = px_ff; py_in = py_ff; qx_in = qx_ff; qy_in = qy_ff;
      npx_in = npx_ff; npy_in = npy_ff;
      acc_in = acc_ff;
      prod_in = mul_a * mul_b;
      qv_in = qv_ff; pv_in = pv_ff;
      t0_in = t0_ff; t1_in = t1_ff;
      stat_in = stat_ff;
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      rstat_in = rstat_ff;
      rx0_in = rx0_ff; ry0_in = ry0_ff; rx1_in = rx1_ff; ry1_in = ry1_ff;
      rd_addr   = idx_ff[VAW-1:0];
      wr_en     = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;

      if (csr_we)
         vcount_in = csr_wdata;

      // result word leaves the output register
      if (rvalid_ff && rsp_ch.ready)
         rvalid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x0_in = '0; y0_in = '0; x1_in = '0; y1_in = '0;
               ax_in = req_ch.ax;
               ay_in = req_ch.ay;
               dx_in = (CW+1)'(req_ch.bx) - (CW+1)'(req_ch.ax);
               dy_in = (CW+1)'(req_ch.by_coord) - (CW+1)'(req_ch.ay);
               t0_in = '0;
               t1_in = ONE_Q16;
               rej_in = 1'b0;
               if (req_ch.opcode == OP_LOAD) begin
                  wr_en    = 1'b1;
                  stat_in  = STAT_LOADED;
                  state_in = ST_DONE;
               end else if (vcount_ff < MIN_COUNT) begin
                  stat_in  = STAT_DEGEN;
                  state_in = ST_DONE;
               end else begin
                  cnt_in   = (vcount_ff > MAX_COUNT) ? MAX_COUNT : vcount_ff;
                  idx_in   = '0;
                  sx_in    = '0;
                  sy_in    = '0;
                  state_in = ST_SUM;
               end
            end
         end

         // vertex sum, one read a cycle
         ST_SUM: begin
            if (rdv_ff) begin
               sx_in = sx_ff + (CW+3)'(signed'(mem_q_ff[CW-1:0]));
               sy_in = sy_ff + (CW+3)'(signed'(mem_q_ff[2*CW-1:CW]));
            end
            if (idx_ff < cnt_ff) begin
               idx_in = idx_nx;
               rdv_in = 1'b1;
            end else if (!rdv_ff) begin
               idx_in   = '0;
               state_in = ST_RDP;
            end
         end

         ST_RDP: begin
            state_in = ST_RDQ;
         end

         ST_RDQ: begin
            px_in   = signed'(mem_q_ff[CW-1:0]);
            py_in   = signed'(mem_q_ff[2*CW-1:CW]);
            rd_addr = last_edge ? '0 : idx_nx[VAW-1:0];
            stp_in  = '0;
            state_in = ST_EDGE;
         end

         // per-edge dot products through the shared multiplier
         ST_EDGE: begin
            stp_in = stp_ff + 4'd1;
            case (stp_ff)
               4'd0: begin
                  qx_in = signed'(mem_q_ff[CW-1:0]);
                  qy_in = signed'(mem_q_ff[2*CW-1:CW]);
               end
               4'd1: npx_in = prod_ff[CW+3:0];
               4'd2: npy_in = prod_ff[CW+3:0];
               4'd3: acc_in = prod_ff;
               4'd4: begin
                  oneg_in = sum2[PW-1];
                  if ((idx_ff == '0) && (sum2 == '0)) begin
                     stat_in  = STAT_DEGEN;
                     state_in = ST_DONE;
                  end
               end
               4'd5: acc_in = prod_ff;
               4'd6: qv_in  = sum2[QW-1:0];
               4'd7: acc_in = prod_ff;
               4'd8: begin
                  pv_in    = sum2[QW-1:0];
                  state_in = ST_DEC;
               end
               default: state_in = ST_DEC;
            endcase
         end

         // parallel, entering or leaving edge
         ST_DEC: begin
            if (pe == '0) begin
               if (qe < 0)
                  rej_in = 1'b1;
            end else if (pe > 0) begin
               if (qe < 0) begin
                  div_start = 1'b1;
                  div_num   = -qe;
                  div_den   = pe;
                  dtgt_in   = 1'b0;
               end
            end else begin
               if (qe < 0) begin
                  rej_in = 1'b1;
               end else begin
                  div_start = 1'b1;
                  div_num   = qe;
                  div_den   = -pe;
                  dtgt_in   = 1'b1;
               end
            end
            stp_in = '0;
            if (div_start) begin
               state_in = ST_DIVW;
            end else if (rej_in || last_edge) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_nx;
               state_in = ST_RDP;
            end
         end

         ST_DIVW: begin
            if (div_done) begin
               if (!dtgt_ff && (div_quo > t0_ff))
                  t0_in = div_quo;
               if (dtgt_ff && (div_quo < t1_ff))
                  t1_in = div_quo;
               if (last_edge) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_nx;
                  state_in = ST_RDP;
               end
            end
         end

         // endpoint interpolation
         ST_FIN: begin
            stp_in = stp_ff + 4'd1;
            case (stp_ff)
               4'd0: begin
                  if (rej_ff || (t1_ff < t0_ff)) begin
                     stat_in  = STAT_REJECTED;
                     state_in = ST_DONE;
                  end
               end
               4'd1: x0_in = lcoord_a + lrp[CW-1:0];
               4'd2: y0_in = lcoord_a + lrp[CW-1:0];
               4'd3: x1_in = lcoord_a + lrp[CW-1:0];
               4'd4: begin
                  y1_in    = lcoord_a + lrp[CW-1:0];
                  stat_in  = STAT_VISIBLE;
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end

         // hand the word to the output register
         ST_DONE: begin
            if (!rvalid_ff || rsp_ch.ready) begin
               rvalid_in = 1'b1;
               rstat_in  = stat_ff;
               rx0_in = x0_ff; ry0_in = y0_ff; rx1_in = x1_ff; ry1_in = y1_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (wr_en)
         vmem[req_ch.vertex_slot] <= {req_ch.ay, req_ch.ax};
      mem_q_ff <= vmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= RESET_COUNT;
         rvalid_ff <= 1'b0;
         rdv_ff    <= 1'b0;
         stp_ff    <= '0;
         idx_ff    <= '0;
         cnt_ff    <= MAX_COUNT;
         rej_ff    <= 1'b0;
         t1_ff     <= ONE_Q16;
         t0_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         rvalid_ff <= rvalid_in;
         rdv_ff    <= rdv_in;
         stp_ff    <= stp_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         rej_ff    <= rej_in;
         t1_ff     <= t1_in;
         t0_ff     <= t0_in;
      end
      dtgt_ff <= dtgt_in;
      oneg_ff <= oneg_in;
      ax_ff <= ax_in; ay_ff <= ay_in; dx_ff <= dx_in; dy_ff <= dy_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      px_ff <= px_in; py_ff <= py_in; qx_ff <= qx_in; qy_ff <= qy_in;
      npx_ff <= npx_in; npy_ff <= npy_in;
      acc_ff <= acc_in; prod_ff <= prod_in;
      qv_ff <= qv_in; pv_ff <= pv_in;
      stat_ff <= stat_in;
      x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      rstat_ff <= rstat_in;
      rx0_ff <= rx0_in; ry0_ff <= ry0_in; rx1_ff <= rx1_in; ry1_ff <= ry1_in;
   end

   assign rsp_ch.valid  = rvalid_ff;
   assign rsp_ch.status = rstat_ff;
   assign rsp_ch.out_x0 = rx0_ff;
   assign rsp_ch.out_y0 = ry0_ff;
   assign rsp_ch.out_x1 = rx1_ff;
   assign rsp_ch.out_y1 = ry1_ff;

   // divider is only started while deciding an edge
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == ST_DEC))
      else $error("divider started outside edge decision");

   // exit parameter never exceeds one
   a_t1_range: assert property (@(posedge clock) disable iff (reset)
      t1_ff <= ONE_Q16)
      else $error("exit parameter above one");

   // an accepted word always starts work
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word dropped");

   // a divider result only arrives while it is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVW))
      else $error("unexpected divider result");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for segment_clip_convex_polygon_core (convex polygon clipper)
// depends on sccp_pkg, sccp_req_if, sccp_rsp_if and the core under hdl
`timescale 1ns / 1ps
module tb_top;
   import sccp_pkg::*;

   localparam longint RUN_LIMIT = 1500000;
   localparam int     HOLD_LEN  = 700;
   localparam int     ITEM_GOAL = 900;

   typedef struct {
      logic             opcode;
      logic [VAW-1:0]   slot;
      coord_type        ax;
      coord_type        ay;
      coord_type        bx;
      coord_type        by_coord;
   } req_word_type;

   typedef struct {
      logic [1:0] status;
      coord_type  x0;
      coord_type  y0;
      coord_type  x1;
      coord_type  y1;
   } clip_word_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CNTW-1:0]  csr_wdata;

   sccp_req_if req_bus ();
   sccp_rsp_if rsp_bus ();

   segment_clip_convex_polygon_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the clipper
   longint          poly_x [MAXV];
   longint          poly_y [MAXV];
   logic [CNTW-1:0] poly_count;

   req_word_type  pending_words [$];
   clip_word_type clip_expected [$];
   req_word_type  offered;
   int         send_gap;
   int         recv_gap;
   int         mismatches;
   int         items_queued;
   bit         calm;
   longint     cycle;
   longint     hold_from;

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= RUN_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // q1.16 quotient, rounded half up, saturated
   function automatic longint unsigned q16_quotient(longint unsigned num, longint unsigned den);
      longint unsigned q, rem;
      q = 0;
      rem = num;
      if (num >= 2 * den) return longint'(MAX_Q16);
      for (int k = 0; k < DIV_STEPS; k++) begin
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
         rem = rem << 1;
      end
      q = (q + 1) >> 1;
      return (q > MAX_Q16) ? longint'(MAX_Q16) : q;
   endfunction

   // a + round(d*t), halves toward plus infinity
   function automatic longint along_segment(longint a, longint d, longint unsigned t);
      longint v;
      v = d * longint'(t) + 32768;
      return a + (v >>> 16);
   endfunction

   // expected word for one accepted item; loads update the shadow store
   function automatic clip_word_type clip_outcome(req_word_type w);
      longint ax, ay, bx, by, sx, sy, n, cr, dx, dy, nx, ny, qv, pv;
      longint unsigned t0, t1, t;
      int cnt, j;
      bit rej;
      clip_word_type r;
      r = '{STAT_VISIBLE, 0, 0, 0, 0};
      ax = w.ax; ay = w.ay; bx = w.bx; by = w.by_coord;
      if (w.opcode == OP_LOAD) begin
         poly_x[w.slot] = ax;
         poly_y[w.slot] = ay;
         r.status = STAT_LOADED;
         return r;
      end
      cnt = poly_count;
      if (cnt < MIN_COUNT) begin
         r.status = STAT_DEGEN;
         return r;
      end
      if (cnt > MAXV) cnt = MAXV;
      n = cnt;
      sx = 0; sy = 0;
      for (int i = 0; i < cnt; i++) begin
         sx += poly_x[i];
         sy += poly_y[i];
      end
      cr = (poly_x[1] - poly_x[0]) * (sy - n * poly_y[0])
         - (poly_y[1] - poly_y[0]) * (sx - n * poly_x[0]);
      if (cr == 0) begin
         r.status = STAT_DEGEN;
         return r;
      end
      dx = bx - ax;
      dy = by - ay;
      t0 = 0;
      t1 = longint'(ONE_Q16);
      rej = 0;
      for (int i = 0; i < cnt; i++) begin
         j = (i + 1) % cnt;
         nx = poly_y[j] - poly_y[i];
         ny = poly_x[i] - poly_x[j];
         // point the normal towards the centroid
         if (nx * (sx - n * poly_x[i]) + ny * (sy - n * poly_y[i]) < 0) begin
            nx = -nx;
            ny = -ny;
         end
         qv = nx * (ax - poly_x[i]) + ny * (ay - poly_y[i]);
         pv = nx * dx + ny * dy;
         if (pv == 0) begin
            if (qv < 0) rej = 1;
         end else if (pv > 0) begin
            if (qv < 0) begin
               t = q16_quotient(-qv, pv);
               if (t > t0) t0 = t;
            end
         end else begin
            if (qv < 0) rej = 1;
            else begin
               t = q16_quotient(qv, -pv);
               if (t < t1) t1 = t;
            end
         end
      end
      if (rej || t1 < t0) begin
         r.status = STAT_REJECTED;
         return r;
      end
      r.x0 = coord_type'(along_segment(ax, dx, t0));
      r.y0 = coord_type'(along_segment(ay, dy, t0));
      r.x1 = coord_type'(along_segment(ax, dx, t1));
      r.y1 = coord_type'(along_segment(ay, dy, t1));
      return r;
   endfunction

   // append to the tail of the pending and expected queues
   task automatic enqueue_word(req_word_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic enqueue_expected(clip_word_type w);
      clip_expected.insert(clip_expected.size(), w);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            enqueue_expected(clip_outcome(offered));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered = pending_words.pop_front();
               req_bus.opcode      <= offered.opcode;
               req_bus.vertex_slot <= offered.slot;
               req_bus.ax          <= offered.ax;
               req_bus.ay          <= offered.ay;
               req_bus.bx          <= offered.bx;
               req_bus.by_coord    <= offered.by_coord;
               req_bus.valid       <= 1'b1;
               send_gap            <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      clip_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap      <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (clip_expected.size() == 0) begin
               $error("unexpected word: status %0d", rsp_bus.status);
               mismatches++;
            end else begin
               want = clip_expected.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.out_x0 !== want.x0) begin
                  $error("out_x0: expected %0d actual %0d", want.x0, rsp_bus.out_x0);
                  mismatches++;
               end
               if (rsp_bus.out_y0 !== want.y0) begin
                  $error("out_y0: expected %0d actual %0d", want.y0, rsp_bus.out_y0);
                  mismatches++;
               end
               if (rsp_bus.out_x1 !== want.x1) begin
                  $error("out_x1: expected %0d actual %0d", want.x1, rsp_bus.out_x1);
                  mismatches++;
               end
               if (rsp_bus.out_y1 !== want.y1) begin
                  $error("out_y1: expected %0d actual %0d", want.y1, rsp_bus.out_y1);
                  mismatches++;
               end
            end
         end
         if (cycle >= hold_from && cycle < hold_from + HOLD_LEN) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            recv_gap      <= pick_gap();
         end
      end
   end

   function automatic coord_type clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return coord_type'(v);
   endfunction

   task automatic add_load(int slot, longint x, longint y);
      enqueue_word('{OP_LOAD, VAW'(slot), clamp16(x), clamp16(y),
                     coord_type'($urandom), coord_type'($urandom)});
      items_queued++;
   endtask

   task automatic add_clip(longint ax, longint ay, longint bx, longint by);
      enqueue_word('{OP_CLIP, VAW'($urandom), clamp16(ax), clamp16(ay),
                     clamp16(bx), clamp16(by)});
      items_queued++;
   endtask

   // wait until the core has drained, then a short settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_words.size() > 0 || req_bus.valid || clip_expected.size() > 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_count(int value);
      csr_we    <= 1'b1;
      csr_wdata <= CNTW'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      poly_count = CNTW'(value);
   endtask

   task automatic load_square();
      add_load(0, 0, 0);
      add_load(1, 100, 0);
      add_load(2, 100, 100);
      add_load(3, 0, 100);
   endtask

   // stimulus
   initial begin
      int phase, want_count, nv, span, clips;
      longint cx, cy, rad, px, py;
      real off, ang;
      bit ccw;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_LOAD;
      req_bus.vertex_slot = '0;
      req_bus.ax = '0;
      req_bus.ay = '0;
      req_bus.bx = '0;
      req_bus.by_coord = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      cycle = 0;
      hold_from = 64'h7fffffffffffffff;
      mismatches = 0;
      items_queued = 0;
      calm = 0;
      poly_count = RESET_COUNT;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 100 by 100 square plus extreme vertices in the upper slots
      set_count(4);
      load_square();
      add_load(4, -32768, 32767);
      add_load(5, 32767, -32768);
      add_load(6, -32768, -32768);
      add_load(7, 32767, 32767);
      add_clip(10, 10, 90, 90);
      add_clip(-50, 50, 150, 50);
      add_clip(150, 50, -50, 50);
      add_clip(200, 200, 300, 300);
      add_clip(200, 10, 200, 90);        // parallel to an edge, outside
      add_clip(-50, 50, 50, -50);        // touches a corner only
      add_clip(150, 50, 200, 50);        // leaving edge behind the start
      add_clip(50, 50, 50, 50);          // zero-length segment
      add_clip(-32768, -32768, 32767, 32767);
      wait_drained();
      set_count(15);                     // saturates to the full store
      add_clip(-32768, 0, 32767, 0);
      wait_drained();
      set_count(0);
      add_clip(1, 2, 3, 4);
      wait_drained();
      set_count(2);
      add_clip(1, 2, 3, 4);
      wait_drained();
      // zero-length edge from a repeated vertex
      set_count(5);
      add_load(4, 0, 100);
      add_clip(-20, 30, 120, 60);
      wait_drained();
      // collinear vertices
      set_count(3);
      add_load(0, 0, 0);
      add_load(1, 10, 10);
      add_load(2, 20, 20);
      add_clip(0, 5, 30, 5);
      wait_drained();

      // random phases: a polygon, then clips around it
      phase = 0;
      while (items_queued < ITEM_GOAL) begin
         wait_drained();
         calm = (phase % 4 == 1);
         if ($urandom_range(0, 99) < 85) want_count = $urandom_range(3, 8);
         else begin
            case ($urandom_range(0, 5))
               0: want_count = 0;
               1: want_count = 1;
               2: want_count = 2;
               3: want_count = 9;
               4: want_count = 12;
               default: want_count = 15;
            endcase
         end
         set_count(want_count);
         nv = (want_count < 3) ? 3 : (want_count > 8 ? 8 : want_count);
         if ($urandom_range(0, 9) == 0) begin
            cx = 0; cy = 0; rad = 32000;
         end else begin
            span = (phase % 3 == 0) ? 40 : 8000;
            rad = $urandom_range(3, span);
            cx = $urandom_range(0, 2 * (32000 - rad)) - (32000 - rad);
            cy = $urandom_range(0, 2 * (32000 - rad)) - (32000 - rad);
         end
         off = $urandom_range(0, 6283) / 1000.0;
         ccw = $urandom_range(0, 1);
         for (int i = 0; i < nv; i++) begin
            ang = off + (ccw ? 1.0 : -1.0) * 6.283185307 * i / nv;
            add_load(i, cx + longint'($rtoi(rad * $cos(ang))),
                     cy + longint'($rtoi(rad * $sin(ang))));
         end
         if (phase == 3) hold_from = cycle + 30;
         clips = $urandom_range(40, 110);
         for (int k = 0; k < clips; k++) begin
            if ($urandom_range(0, 99) < 3) begin
               add_load($urandom_range(0, 7), $signed(16'($urandom)), $signed(16'($urandom)));
            end else if ($urandom_range(0, 99) < 80) begin
               px = 2 * rad;
               add_clip(cx + $urandom_range(0, 2 * px) - px, cy + $urandom_range(0, 2 * px) - px,
                        cx + $urandom_range(0, 2 * px) - px, cy + $urandom_range(0, 2 * px) - px);
            end else begin
               add_clip($signed(16'($urandom)), $signed(16'($urandom)),
                        $signed(16'($urandom)), $signed(16'($urandom)));
            end
         end
         phase++;
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sccp_pkg.sv
hdl/sccp_if.sv
hdl/sccp_div.sv
hdl/segment_clip_convex_polygon_core.sv
sim/tb_top.sv
